FILE: rtl/dltq_pkg.sv
// Package for the delta-list timer queue: command and result beat types, mode codes.
// No dependencies.
`timescale 1ns / 1ps
package dltq_pkg;
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  timer_id;
        logic [31:0] interval;
        logic        periodic;
    } t_cmd;

    typedef struct packed {
        logic [3:0] expired_id;
        logic       last;
    } t_result;
endpackage

FILE: rtl/delta_list_timer_queue.sv
// Delta-list timer queue top level: list memories, walk sequencer, result strobe.
// Depends on dltq_pkg.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive i_cmd and pulse i_start while o_busy is low; the beat
//   is taken at that edge. Modes: tick, start timer, stop timer, clear all.
//   Result channel: each expired timer shows on o_result for one cycle with
//   o_valid high; o_result.last marks the final expiry of a tick. The receiver
//   cannot stall, so every result is taken the cycle it is shown.
//   The list lives in one synchronous memory (id + delta per position, one
//   read and one write a cycle, read data registered). Start and stop walk
//   the list one position at a time (read, then use the data); start then
//   shifts the tail up, stop shifts the tail down. Clear and an ignored
//   start or stop keep o_busy low, so the next beat can follow at once.
//   A tick checks the head; each expiry brings the pop shift and, for a
//   periodic timer, the reload read and the reinsert. Each expiry strobes
//   at the next head check; the final one strobes in the first cycle with
//   o_busy low.
//   Reset: list count and running flags clear; list memory and reload store
//   hold no reset value and are only read below the count.
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int NUM_TIMERS    = 16,
    parameter int INTERVAL_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);
    localparam int PW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int IW = INTERVAL_BITS;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INS_RD = 4'd1;  // issue read of position r_pos
    localparam logic [3:0] S_INS_CK = 4'd2;  // compare with read data
    localparam logic [3:0] S_INS_SH = 4'd3;  // shift up: read k-1
    localparam logic [3:0] S_INS_SW = 4'd4;  // write k with read data
    localparam logic [3:0] S_STP_RD = 4'd5;
    localparam logic [3:0] S_STP_CK = 4'd6;
    localparam logic [3:0] S_REM_RD = 4'd7;  // shift down: read k+1
    localparam logic [3:0] S_REM_WR = 4'd8;
    localparam logic [3:0] S_TCK_RD = 4'd9;
    localparam logic [3:0] S_TCK_CK = 4'd10;
    localparam logic [3:0] S_TCK_FX = 4'd11; // start reinsert of popped periodic timer
    localparam logic [3:0] S_TCK_FW = 4'd12; // wait for the reload read

    typedef struct packed {
        logic [3:0]    id;
        logic [IW-1:0] delta;
    } t_entry;

    // list memory: one write and one registered read a cycle
    t_entry r_mem [NUM_TIMERS];
    t_entry r_rd;
    logic   mem_we;
    logic [PW-1:0] mem_wa, mem_ra;
    t_entry mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    // per-timer reload store
    logic [IW-1:0] r_reload [NUM_TIMERS];
    logic [IW-1:0] r_reload_rd;
    logic [NUM_TIMERS-1:0] r_per;
    logic [NUM_TIMERS-1:0] r_run, n_run;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_pos, n_pos;     // walk position
    logic [CW-1:0] r_k, n_k;         // shift index
    logic [IW-1:0] r_left, n_left;   // insert time left
    logic [3:0]    r_id, n_id;       // id being inserted / stopped
    logic [IW-1:0] r_carry, n_carry; // delta handed to successor on removal
    logic          r_elapsed, n_elapsed; // tick time not yet consumed (0 or 1)
    logic          r_tick, n_tick;   // insert runs inside a tick
    logic          r_pend, n_pend;   // a result waits for its last flag
    logic [3:0]    r_pid, n_pid;
    logic          r_valid, n_valid;
    t_result       r_res, n_res;
    logic          ld_we;
    logic [3:0]    ld_id;
    logic [IW-1:0] ld_val;
    logic          ld_per;

    logic [IW-1:0] cmd_ival;
    logic          cmd_ok;
    always_comb begin
        cmd_ival = IW'(i_cmd.interval);
        if (cmd_ival == '0) begin
            cmd_ival = IW'(1);
        end
        cmd_ok = (32'(i_cmd.timer_id) < 32'(NUM_TIMERS));
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_pos = r_pos; n_k = r_k;
        n_left = r_left; n_id = r_id; n_carry = r_carry;
        n_elapsed = r_elapsed; n_tick = r_tick;
        n_pend = r_pend; n_pid = r_pid; n_run = r_run;
        n_valid = 1'b0; n_res = r_res;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
        ld_we = 1'b0; ld_id = i_cmd.timer_id; ld_val = cmd_ival;
        ld_per = i_cmd.periodic;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd.mode)
                        MODE_START: begin
                            if (cmd_ok && !r_run[PW'(i_cmd.timer_id)]) begin
                                ld_we = 1'b1;
                                n_id = i_cmd.timer_id;
                                n_left = cmd_ival;
                                n_pos = '0;
                                n_tick = 1'b0;
                                n_state = S_INS_RD;
                            end
                        end
                        MODE_STOP: begin
                            if (cmd_ok && r_run[PW'(i_cmd.timer_id)]) begin
                                n_id = i_cmd.timer_id;
                                n_pos = '0;
                                n_state = S_STP_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            n_cnt = '0;
                            n_run = '0;
                        end
                        default: begin
                            n_elapsed = 1'b1;
                            n_pend = 1'b0;
                            n_state = S_TCK_RD;
                        end
                    endcase
                end
            end
            // insertion: walk to the place, then shift the tail up
            S_INS_RD: begin
                if (r_pos >= r_cnt) begin
                    n_k = r_cnt;
                    n_state = S_INS_SH;
                end else begin
                    mem_ra = r_pos[PW-1:0];
                    n_state = S_INS_CK;
                end
            end
            S_INS_CK: begin
                if (r_left < r_rd.delta) begin
                    mem_we = 1'b1;
                    mem_wa = r_pos[PW-1:0];
                    mem_wd.id = r_rd.id;
                    mem_wd.delta = r_rd.delta - r_left;
                    n_k = r_cnt;
                    n_state = S_INS_SH;
                end else begin
                    n_left = r_left - r_rd.delta;
                    n_pos = r_pos + CW'(1);
                    n_state = S_INS_RD;
                end
            end
            S_INS_SH: begin
                if (r_k > r_pos) begin
                    mem_ra = PW'(r_k - CW'(1));
                    n_state = S_INS_SW;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_pos[PW-1:0];
                    mem_wd.id = r_id;
                    mem_wd.delta = r_left;
                    n_cnt = r_cnt + CW'(1);
                    n_run[PW'(r_id)] = 1'b1;
                    n_state = r_tick ? S_TCK_RD : S_IDLE;
                end
            end
            S_INS_SW: begin
                mem_we = 1'b1;
                mem_wa = r_k[PW-1:0];
                mem_wd = r_rd;
                n_k = r_k - CW'(1);
                n_state = S_INS_SH;
            end
            // stop: find the timer, then remove it
            S_STP_RD: begin
                mem_ra = r_pos[PW-1:0];
                n_state = S_STP_CK;
            end
            S_STP_CK: begin
                if (r_rd.id == r_id) begin
                    n_run[PW'(r_id)] = 1'b0;
                    n_carry = r_rd.delta;
                    n_k = r_pos;
                    n_tick = 1'b0;
                    n_state = S_REM_RD;
                end else begin
                    n_pos = r_pos + CW'(1);
                    n_state = S_STP_RD;
                end
            end
            // shift down from r_k, adding the carry to the first successor
            S_REM_RD: begin
                if (r_k + CW'(1) < r_cnt) begin
                    mem_ra = PW'(r_k + CW'(1));
                    n_state = S_REM_WR;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                    if (r_tick) begin
                        n_state = S_TCK_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REM_WR: begin
                mem_we = 1'b1;
                mem_wa = r_k[PW-1:0];
                mem_wd.id = r_rd.id;
                mem_wd.delta = r_rd.delta + r_carry;
                n_carry = '0;
                n_k = r_k + CW'(1);
                n_state = S_REM_RD;
            end
            // tick: check head, pop when due
            S_TCK_RD: begin
                if (r_pend && !(r_cnt != '0)) begin
                    n_valid = 1'b1;
                    n_res.expired_id = r_pid;
                    n_res.last = 1'b1;
                    n_pend = 1'b0;
                    n_state = S_IDLE;
                end else if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    mem_ra = '0;
                    n_state = S_TCK_CK;
                end
            end
            S_TCK_CK: begin
                if (r_rd.delta <= IW'(r_elapsed)) begin
                    // pop head: emit the held result, hold this one
                    if (r_pend) begin
                        n_valid = 1'b1;
                        n_res.expired_id = r_pid;
                        n_res.last = 1'b0;
                    end
                    n_pend = 1'b1;
                    n_pid = r_rd.id;
                    n_elapsed = r_elapsed & (r_rd.delta == '0);
                    n_run[PW'(r_rd.id)] = 1'b0;
                    n_carry = '0;
                    n_k = '0;
                    n_tick = 1'b1;
                    n_state = S_REM_RD;
                    if (r_per[PW'(r_rd.id)]) begin
                        n_state = S_REM_RD;
                    end
                end else begin
                    mem_we = 1'b1;
                    mem_wa = '0;
                    mem_wd.id = r_rd.id;
                    mem_wd.delta = r_rd.delta - IW'(r_elapsed);
                    if (r_pend) begin
                        n_valid = 1'b1;
                        n_res.expired_id = r_pid;
                        n_res.last = 1'b1;
                        n_pend = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_TCK_FX: begin
                // reinsert the periodic timer just popped
                n_id = r_pid;
                n_left = r_reload_rd;
                n_pos = '0;
                n_tick = 1'b1;
                n_state = S_INS_RD;
            end
            S_TCK_FW: begin
                n_state = S_TCK_FX;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // after a tick pop shifts down, reinsert periodic timers before next check
        if (r_state == S_REM_RD && r_tick && !(r_k + CW'(1) < r_cnt)
            && r_per[PW'(r_pid)] && r_pend) begin
            n_state = S_TCK_FW;
        end
        if (r_state == S_TCK_FX) begin
            n_state = S_INS_RD;
        end
    end

    // the reinsert path must not loop back to itself: mark it done on entry
    logic r_reins, n_reins;
    always_comb begin
        n_reins = r_reins;
        if (r_state == S_TCK_FW) begin
            n_reins = 1'b1;
        end else if (r_state == S_TCK_CK || r_state == S_IDLE) begin
            n_reins = 1'b0;
        end
    end

    logic [3:0] fix_state;
    always_comb begin
        fix_state = n_state;
        if (r_reins && n_state == S_TCK_FW) begin
            fix_state = S_TCK_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_we) begin
            r_reload[PW'(ld_id)] <= ld_val;
            r_per[PW'(ld_id)]    <= ld_per;
        end
        r_reload_rd <= r_reload[PW'(r_pid)];
        r_pos <= n_pos; r_k <= n_k; r_left <= n_left; r_id <= n_id;
        r_carry <= n_carry; r_elapsed <= n_elapsed; r_pid <= n_pid;
        r_res <= n_res;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_run   <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_tick  <= 1'b0;
            r_reins <= 1'b0;
        end else begin
            r_state <= fix_state;
            r_cnt   <= n_cnt;
            r_run   <= n_run;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_tick  <= n_tick;
            r_reins <= n_reins;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NUM_TIMERS)) else $error("list count overflow");
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_run) == 32'(r_cnt)))
        else $error("running flags disagree with list count");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_cmd.mode == MODE_CLEAR) |=> (r_cnt == '0))
        else $error("clear did not empty list");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == S_IDLE && !i_start) |-> !r_valid)
        else $error("result without command");
`endif
endmodule

FILE: tb/testbench.sv
// Testbench for delta_list_timer_queue: directed and random command beats checked
// against a behavioral delta-list predictor. Depends on dltq_pkg and the RTL top.
`timescale 1ns / 1ps
module testbench;
    import dltq_pkg::*;

    localparam int NT       = 16;
    localparam int IDLE_MAX = 20000;   // cycles with no beat taken and no result

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    t_cmd    i_cmd;
    logic    o_busy;
    logic    o_valid;
    t_result o_result;

    int errors;
    int idle_cycles;

    // Predictor state: ordered list of timer ids with per-position deltas.
    logic [3:0]  slot_id[NT];
    logic [31:0] slot_delta[NT];
    int          slot_count;
    bit          running[NT];
    logic [31:0] reload[NT];
    bit          periodic[NT];

    // Expiries predicted but not yet seen on the result port.
    t_result expiry_q[$];

    delta_list_timer_queue DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Insert a timer at its place; equal times go behind those already queued.
    function automatic void list_insert(int id);
        logic [31:0] left;
        int pos;
        left = reload[id];
        pos = 0;
        if (slot_count >= NT) return;
        while (pos < slot_count) begin
            if (left < slot_delta[pos]) begin
                slot_delta[pos] = slot_delta[pos] - left;
                break;
            end
            left = left - slot_delta[pos];
            pos++;
        end
        for (int k = slot_count; k > pos; k--) begin
            slot_id[k] = slot_id[k-1];
            slot_delta[k] = slot_delta[k-1];
        end
        slot_id[pos] = id[3:0];
        slot_delta[pos] = left;
        slot_count++;
        running[id] = 1'b1;
    endfunction

    // Drop a position and hand its delta to the successor.
    function automatic void list_remove(int pos);
        running[slot_id[pos]] = 1'b0;
        if (pos + 1 < slot_count) slot_delta[pos+1] = slot_delta[pos+1] + slot_delta[pos];
        for (int k = pos; k + 1 < slot_count; k++) begin
            slot_id[k] = slot_id[k+1];
            slot_delta[k] = slot_delta[k+1];
        end
        slot_count--;
    endfunction

    // Advance the predicted queue by one command beat and queue its expiries.
    function automatic void predict_expiries(t_cmd c);
        logic [31:0] elapsed;
        logic [31:0] ival;
        int id;
        int n;
        t_result r;
        id = c.timer_id;
        n = 0;
        case (c.mode)
            MODE_START: begin
                if (!running[id]) begin
                    ival = (c.interval == 32'd0) ? 32'd1 : c.interval;
                    reload[id] = ival;
                    periodic[id] = c.periodic;
                    list_insert(id);
                end
            end
            MODE_STOP: begin
                for (int p = 0; p < slot_count; p++) begin
                    if (slot_id[p] == c.timer_id) begin
                        list_remove(p);
                        break;
                    end
                end
            end
            MODE_CLEAR: begin
                slot_count = 0;
                for (int k = 0; k < NT; k++) running[k] = 1'b0;
            end
            default: begin
                elapsed = 32'd1;
                while (slot_count > 0 && slot_delta[0] <= elapsed && n < NT) begin
                    id = slot_id[0];
                    elapsed = elapsed - slot_delta[0];
                    for (int k = 0; k + 1 < slot_count; k++) begin
                        slot_id[k] = slot_id[k+1];
                        slot_delta[k] = slot_delta[k+1];
                    end
                    slot_count--;
                    running[id] = 1'b0;
                    if (periodic[id]) list_insert(id);
                    r.expired_id = id[3:0];
                    r.last = 1'b0;
                    expiry_q.push_back(r);
                    n++;
                end
                if (slot_count > 0) slot_delta[0] = slot_delta[0] - elapsed;
                // Mark the final expiry of this tick.
                if (n > 0) expiry_q[expiry_q.size()-1].last = 1'b1;
            end
        endcase
    endfunction

    // Mostly short gaps, now and then a long one, often none.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one command beat; returns at the falling edge after it is taken.
    task automatic send_cmd(logic [1:0] mode, int id, logic [31:0] ival, bit per);
        t_cmd c;
        int gap;
        c.mode = mode;
        c.timer_id = id[3:0];
        c.interval = ival;
        c.periodic = per;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd <= c;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_expiries(c);
        @(negedge i_clk);
    endtask

    task automatic tick_n(int n);
        repeat (n) send_cmd(MODE_TICK, $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
    endtask

    // Check each result strobe against the oldest predicted expiry; run the watchdog.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                if (expiry_q.size() == 0) begin
                    $display("%0t: unexpected result id=%0d last=%0b",
                             $time, o_result.expired_id, o_result.last);
                    errors++;
                end else begin
                    want = expiry_q.pop_front();
                    if (o_result.expired_id !== want.expired_id) begin
                        $display("%0t: expired_id expected %0d actual %0d",
                                 $time, want.expired_id, o_result.expired_id);
                        errors++;
                    end
                    if (o_result.last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, o_result.last);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // One-shot timers of distinct and equal lengths, popped in order.
    task automatic test_one_shot_order();
        send_cmd(MODE_START, 3, 32'd2, 1'b0);
        send_cmd(MODE_START, 7, 32'd2, 1'b0);   // equal time: behind timer 3
        send_cmd(MODE_START, 0, 32'd1, 1'b0);
        send_cmd(MODE_START, 15, 32'd3, 1'b0);
        tick_n(4);
    endtask

    // Zero interval is raised to one; a start of a running timer is ignored.
    task automatic test_zero_and_restart();
        send_cmd(MODE_START, 5, 32'd0, 1'b0);
        send_cmd(MODE_START, 5, 32'd9, 1'b1);
        send_cmd(MODE_TICK, 0, 32'd0, 1'b0);
        send_cmd(MODE_TICK, 0, 32'd0, 1'b0);  // nothing due
    endtask

    // Stop of head and idle timers; successor inherits the delta.
    task automatic test_stop();
        send_cmd(MODE_START, 1, 32'd1, 1'b0);
        send_cmd(MODE_START, 2, 32'd3, 1'b0);
        send_cmd(MODE_START, 4, 32'd4, 1'b0);
        send_cmd(MODE_STOP, 1, 32'd0, 1'b0);
        send_cmd(MODE_STOP, 9, 32'd0, 1'b0);   // idle timer
        tick_n(4);
    endtask

    // Periodic timers reload and interleave with one-shots.
    task automatic test_periodic();
        send_cmd(MODE_START, 8, 32'd1, 1'b1);
        send_cmd(MODE_START, 10, 32'd2, 1'b1);
        send_cmd(MODE_START, 12, 32'd2, 1'b0);
        tick_n(4);
        send_cmd(MODE_STOP, 8, 32'd0, 1'b0);
        send_cmd(MODE_CLEAR, 0, 32'd0, 1'b0);
        tick_n(1);
    endtask

    // Widest interval, then fill the list and clear it.
    task automatic test_extremes_and_clear();
        send_cmd(MODE_START, 14, 32'hFFFF_FFFF, 1'b1);
        for (int k = 0; k < NT; k++) send_cmd(MODE_START, k, 32'd1, 1'b1);
        tick_n(2);
        send_cmd(MODE_CLEAR, 15, 32'hFFFF_FFFF, 1'b1);
        tick_n(1);
    endtask

    // Random mix, weighted toward short intervals so ticks pop timers often.
    task automatic test_random(int count);
        int roll;
        logic [31:0] ival;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) ival = $urandom;
            else ival = $urandom_range(0, 5);
            if (roll < 50) send_cmd(MODE_TICK, $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
            else if (roll < 85) send_cmd(MODE_START, $urandom_range(0, 15), ival, $urandom_range(0, 1));
            else if (roll < 96) send_cmd(MODE_STOP, $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
            else send_cmd(MODE_CLEAR, $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
        end
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        slot_count = 0;
        for (int k = 0; k < NT; k++) begin
            running[k] = 1'b0;
            periodic[k] = 1'b0;
            reload[k] = 32'd0;
        end
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_one_shot_order();
        test_zero_and_restart();
        test_stop();
        test_periodic();
        test_extremes_and_clear();
        test_random(118);

        i_start <= 1'b0;
        while (expiry_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expiry_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (expiry_q.size() != 0) $display("%0t: %0d expiries never arrived", $time, expiry_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: delta_list_timer_queue.f
rtl/dltq_pkg.sv
rtl/delta_list_timer_queue.sv
tb/testbench.sv
